FILE: sv/htbd_pkg.sv
// Shared types and constants for the Huffman tree build and decode unit.
package htbd_pkg;

  localparam int SYM_W = 8;
  localparam int CNT_W = 24;

  typedef enum logic [1:0] {
    OP_BUILD  = 2'd0,
    OP_DECODE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_SYMBOL  = 3'd1,
    KIND_INVALID = 3'd2,
    KIND_IGNORED = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  typedef struct packed {
    op_t              op;
    logic             bit_req;
    logic             code_end;
    logic [SYM_W-1:0] symbol;
  } in_req_t;

  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] out_symbol;
    logic             final_symbol;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LEAF,
    ST_ALLOC
  } state_t;

  typedef struct packed {
    logic accept;
    logic eval_go;
    logic pay_rd;
    logic leaf_go;
    logic zero_wr;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic halted;
    logic child_zero;
    logic store_full;
  } sts_t;

endpackage

FILE: sv/htbd_ctrl.sv
// Sequencer for the tree unit: request handshake, stage order and output valid.
module htbd_ctrl import htbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load_out;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // a live decode step with a child present must look at the child's leaf mark
        if (sts.op == OP_DECODE && !sts.halted && !sts.child_zero) begin
          cmd.pay_rd = 1'b1;
          state_nxt  = ST_LEAF;
        end else if (out_free) begin
          cmd.eval_go = 1'b1;
          load_out    = 1'b1;
          if (sts.op == OP_BUILD && sts.child_zero && !sts.store_full) begin
            state_nxt = ST_ALLOC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LEAF: begin
        if (out_free) begin
          cmd.leaf_go = 1'b1;
          load_out    = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        // clear the links of the freshly allocated node
        cmd.zero_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/htbd_datapath.sv
// Node store, cursors, counters and result register of the tree unit.
module htbd_datapath import htbd_pkg::*; #(
  parameter int NODES = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_req_t          in_data,
  input  logic             cfg_valid,
  input  logic [CNT_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output out_rsp_t         out_data
);

  localparam int AW = $clog2(NODES);
  localparam int FW = $clog2(NODES + 1);
  localparam int LW = 2 * AW;
  localparam int PW = SYM_W + 1;

  // link word: left child in the upper half, right child in the lower half
  logic [LW-1:0] link_mem [NODES];
  // payload word: symbol above the leaf mark
  logic [PW-1:0] pay_mem  [NODES];

  logic [AW-1:0]    bld_cur_r, dec_cur_r;
  logic [FW-1:0]    free_r;
  logic [CNT_W-1:0] count_r, limit_r;
  logic             halted_r;
  logic [AW-1:0]    root_left_r, root_right_r;

  in_req_t          item_r;
  logic             rd_root_r;
  logic [LW-1:0]    link_q_r;
  logic [PW-1:0]    pay_q_r;
  logic [AW-1:0]    nxt_r;
  out_rsp_t         out_data_r;

  logic [AW-1:0]    rd_addr;
  logic [LW-1:0]    cur_link;
  logic [AW-1:0]    child;
  logic             child_zero;
  logic             full;
  logic [AW-1:0]    alloc_idx;
  logic             is_build;
  logic             alloc;
  logic [LW-1:0]    upd_link;
  logic             link_we;
  logic [AW-1:0]    link_wa;
  logic [LW-1:0]    link_wd;
  logic             pay_we;
  logic [AW-1:0]    pay_wa;
  logic [PW-1:0]    pay_wd;
  logic             pay_leaf;
  logic [SYM_W-1:0] pay_sym;
  logic [CNT_W-1:0] count_inc;
  logic             fin;
  out_rsp_t         res;

  assign rd_addr    = (in_data.op == OP_DECODE) ? dec_cur_r : bld_cur_r;
  assign cur_link   = rd_root_r ? {root_left_r, root_right_r} : link_q_r;
  assign child      = item_r.bit_req ? cur_link[AW-1:0] : cur_link[LW-1:AW];
  assign child_zero = (child == '0);
  assign full       = (free_r >= FW'(NODES));
  assign alloc_idx  = free_r[AW-1:0];
  assign is_build   = (item_r.op == OP_BUILD);
  assign alloc      = cmd.eval_go && is_build && child_zero && !full;
  assign upd_link   = item_r.bit_req ? {cur_link[LW-1:AW], alloc_idx}
                                     : {alloc_idx, cur_link[AW-1:0]};

  // root links live in flops; the memory never holds entry zero
  always_comb begin
    link_we = 1'b0;
    link_wa = nxt_r;
    link_wd = '0;
    if (cmd.zero_wr) begin
      link_we = 1'b1;
    end else if (alloc && bld_cur_r != '0) begin
      link_we = 1'b1;
      link_wa = bld_cur_r;
      link_wd = upd_link;
    end
  end

  assign pay_we = alloc ||
                  (cmd.eval_go && is_build && item_r.code_end && !child_zero);
  assign pay_wa = child_zero ? alloc_idx : child;
  assign pay_wd = item_r.code_end ? {item_r.symbol, 1'b1} : '0;

  assign pay_leaf  = pay_q_r[0];
  assign pay_sym   = pay_q_r[PW-1:1];
  assign count_inc = count_r + 1'b1;
  assign fin       = (limit_r != '0) && (count_inc >= limit_r);

  always_comb begin
    res = '{kind: KIND_NONE, out_symbol: '0, final_symbol: 1'b0};
    if (cmd.leaf_go) begin
      if (pay_leaf) begin
        res.kind         = KIND_SYMBOL;
        res.out_symbol   = pay_sym;
        res.final_symbol = fin;
      end
    end else begin
      unique case (item_r.op)
        OP_BUILD: begin
          if (child_zero && full) begin
            res.kind = KIND_FULL;
          end
        end
        OP_DECODE: begin
          res.kind = halted_r ? KIND_IGNORED : KIND_INVALID;
        end
        default: begin
          res.kind = KIND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      link_q_r <= link_mem[rd_addr];
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.pay_rd) begin
      pay_q_r <= pay_mem[child];
    end
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r    <= in_data;
      rd_root_r <= (rd_addr == '0);
    end
    if (cmd.pay_rd) begin
      nxt_r <= child;
    end else if (alloc) begin
      nxt_r <= alloc_idx;
    end
    if (cmd.eval_go || cmd.leaf_go) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bld_cur_r    <= '0;
      dec_cur_r    <= '0;
      free_r       <= FW'(1);
      count_r      <= '0;
      limit_r      <= '0;
      halted_r     <= 1'b0;
      root_left_r  <= '0;
      root_right_r <= '0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (cmd.eval_go) begin
        unique case (item_r.op)
          OP_CLEAR: begin
            bld_cur_r    <= '0;
            dec_cur_r    <= '0;
            free_r       <= FW'(1);
            count_r      <= '0;
            halted_r     <= 1'b0;
            root_left_r  <= '0;
            root_right_r <= '0;
          end
          OP_BUILD: begin
            if (child_zero && full) begin
              // drop the code and restart at the root
              bld_cur_r <= '0;
            end else begin
              if (child_zero) begin
                free_r <= free_r + 1'b1;
                if (bld_cur_r == '0) begin
                  root_left_r  <= upd_link[LW-1:AW];
                  root_right_r <= upd_link[AW-1:0];
                end
              end
              if (item_r.code_end) begin
                bld_cur_r <= '0;
              end else begin
                bld_cur_r <= child_zero ? alloc_idx : child;
              end
            end
          end
          OP_DECODE: begin
            // only a missing child or an earlier halt finishes here
            halted_r <= 1'b1;
          end
          default: begin
            halted_r <= halted_r;
          end
        endcase
      end
      if (cmd.leaf_go) begin
        if (pay_leaf) begin
          count_r   <= count_inc;
          dec_cur_r <= '0;
          if (fin) begin
            halted_r <= 1'b1;
          end
        end else begin
          dec_cur_r <= nxt_r;
        end
      end
    end
  end

  assign sts.op         = item_r.op;
  assign sts.halted     = halted_r;
  assign sts.child_zero = child_zero;
  assign sts.store_full = full;
  assign out_data       = out_data_r;

endmodule

FILE: sv/huffman_tree_build_and_decode_unit.sv
// Top level of the Huffman tree build and decode unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in_     | input     | in_valid/in_ready   | in_req_t: op, bit_req, code_end,
//           |           |                     |           symbol
//   out_    | output    | out_valid/out_ready | out_rsp_t: kind, out_symbol,
//           |           |                     |            final_symbol
//   cfg_    | input     | cfg_valid/cfg_ready | symbol_limit (24 bits)
//
// One request at a time, stepped by the node store's registered reads. A build
// goes on to an allocate state for the second link write when it allocates a node;
// a decode goes on to a leaf state to read the child's leaf mark unless it halts or
// finds no child. Clear and unused ops end at evaluation; a held result stalls only
// the finishing state. Reset is synchronous and takes effect at once; no clearing
// pass is needed. The configuration port is always ready.
module huffman_tree_build_and_decode_unit import htbd_pkg::*; #(
  parameter int NODES = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  htbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  htbd_datapath #(
    .NODES (NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

FILE: sv/htbd_checker.sv
// Port-level checks for the tree unit, bound to the top level.
module htbd_checker import htbd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input in_req_t          in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_rsp_t         out_data
);

  // hold a waiting request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request changed or dropped");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // one request in flight: in_ready drops once a request is accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in flight");

  // only an emitted symbol carries symbol bits or the final flag
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_SYMBOL |->
      out_data.out_symbol == '0 && !out_data.final_symbol)
    else $error("symbol fields set on a non-symbol result");

  // reset drops any pending result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind huffman_tree_build_and_decode_unit htbd_checker u_htbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the Huffman tree build and decode unit.
module tb_top import htbd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_NODES = 512;
  localparam int IDX_W = $clog2(TREE_NODES);
  localparam int MAX_CODES = 16;
  localparam int MAX_CODE_LEN = 12;
  localparam int DIR_ROWS = 24;
  localparam int ITEM_TARGET = 1175;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0] LIMIT_MAX = '1;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_req_t          in_data;
  logic             out_valid;
  logic             out_ready;
  out_rsp_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  huffman_tree_build_and_decode_unit #(
    .NODES(TREE_NODES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the code tree and the decoder state
  logic [IDX_W-1:0] node_left  [TREE_NODES];
  logic [IDX_W-1:0] node_right [TREE_NODES];
  logic [SYM_W-1:0] node_sym   [TREE_NODES];
  logic             node_leaf  [TREE_NODES];
  logic [IDX_W:0]   next_node;
  logic [IDX_W-1:0] build_at;
  logic [IDX_W-1:0] decode_at;
  logic [CNT_W-1:0] decoded_cnt;
  logic             decode_stopped;
  logic [CNT_W-1:0] limit_shadow;

  in_req_t  bit_reqs_pending [$];
  out_rsp_t answers_due [$];

  // Code set used to build a tree and to form decode streams
  logic [MAX_CODE_LEN-1:0] code_bits [MAX_CODES];
  int                      code_len  [MAX_CODES];
  logic [SYM_W-1:0]        code_sym  [MAX_CODES];
  int                      code_cnt;

  dir_row_t dir_tab [DIR_ROWS];

  int   cycle_cnt = 0;
  int   err_cnt = 0;
  int   reqs_queued = 0;
  int   answers_checked = 0;
  int   symbols_seen = 0;
  int   invalid_seen = 0;
  int   full_seen = 0;
  int   full_predicted = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  logic in_fire = 1'b0;

  function automatic void reset_tree();
    node_left[0] = '0;
    node_right[0] = '0;
    node_sym[0] = '0;
    node_leaf[0] = 1'b0;
    next_node = (IDX_W+1)'(1);
    build_at = '0;
    decode_at = '0;
    decoded_cnt = '0;
    decode_stopped = 1'b0;
  endfunction

  function automatic out_rsp_t walk_tree(input in_req_t r);
    out_rsp_t         rsp;
    logic [IDX_W-1:0] nxt;
    rsp = '0;
    rsp.kind = KIND_NONE;
    case (r.op)
      OP_CLEAR: reset_tree();
      OP_BUILD: begin
        nxt = r.bit_req ? node_right[build_at] : node_left[build_at];
        if (nxt == '0) begin
          if (next_node >= (IDX_W+1)'(TREE_NODES)) begin
            // drop the code under way
            build_at = '0;
            rsp.kind = KIND_FULL;
          end else begin
            nxt = next_node[IDX_W-1:0];
            next_node = next_node + 1'b1;
            node_left[nxt] = '0;
            node_right[nxt] = '0;
            node_sym[nxt] = '0;
            node_leaf[nxt] = 1'b0;
            if (r.bit_req) node_right[build_at] = nxt;
            else node_left[build_at] = nxt;
          end
        end
        if (rsp.kind == KIND_NONE) begin
          if (r.code_end) begin
            node_sym[nxt] = r.symbol;
            node_leaf[nxt] = 1'b1;
            build_at = '0;
          end else begin
            build_at = nxt;
          end
        end
      end
      OP_DECODE: begin
        if (decode_stopped) begin
          rsp.kind = KIND_IGNORED;
        end else begin
          nxt = r.bit_req ? node_right[decode_at] : node_left[decode_at];
          if (nxt == '0) begin
            decode_stopped = 1'b1;
            rsp.kind = KIND_INVALID;
          end else if (node_leaf[nxt]) begin
            rsp.kind = KIND_SYMBOL;
            rsp.out_symbol = node_sym[nxt];
            decoded_cnt = decoded_cnt + 1'b1;
            decode_at = '0;
            if (limit_shadow != '0 && decoded_cnt >= limit_shadow) begin
              rsp.final_symbol = 1'b1;
              decode_stopped = 1'b1;
            end
          end else begin
            decode_at = nxt;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic in_req_t make_req(input op_t op, input logic b, input logic e,
                                       input logic [SYM_W-1:0] s);
    in_req_t r;
    r.op = op;
    r.bit_req = b;
    r.code_end = e;
    r.symbol = s;
    return r;
  endfunction

  function automatic dir_row_t row(input op_t op, input logic b, input logic e,
                                   input logic [SYM_W-1:0] s);
    dir_row_t d;
    d.req = make_req(op, b, e, s);
    d.typed = 1'b0;
    d.rsp = '0;
    return d;
  endfunction

  function automatic dir_row_t row_exp(input op_t op, input logic b, input logic e,
                                       input logic [SYM_W-1:0] s, input kind_t k,
                                       input logic [SYM_W-1:0] os, input logic fin);
    dir_row_t d;
    d = row(op, b, e, s);
    d.typed = 1'b1;
    d.rsp.kind = k;
    d.rsp.out_symbol = os;
    d.rsp.final_symbol = fin;
    return d;
  endfunction

  task automatic queue_req(input in_req_t r, input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t rsp;
    rsp = walk_tree(r);
    if (rsp.kind == KIND_FULL) full_predicted++;
    answers_due.push_back(typed ? typed_rsp : rsp);
    bit_reqs_pending.push_back(r);
    reqs_queued++;
  endtask

  task automatic queue_bit(input op_t op, input logic b, input logic e,
                           input logic [SYM_W-1:0] s);
    queue_req(make_req(op, b, e, s), 1'b0, '0);
  endtask

  task automatic maybe_noise(input int pct);
    if ($urandom_range(0, 99) < pct)
      queue_bit(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
  endtask

  // Split random leaves until the prefix-free set has the wanted size
  task automatic grow_code_set();
    int want;
    int pick;
    want = $urandom_range(2, MAX_CODES);
    code_bits[0] = '0;
    code_len[0] = 1;
    code_bits[1] = MAX_CODE_LEN'(1);
    code_len[1] = 1;
    code_cnt = 2;
    while (code_cnt < want) begin
      pick = $urandom_range(0, code_cnt - 1);
      if (code_len[pick] < MAX_CODE_LEN) begin
        code_bits[code_cnt] = code_bits[pick] | (MAX_CODE_LEN'(1) << code_len[pick]);
        code_len[code_cnt] = code_len[pick] + 1;
        code_len[pick]++;
        code_cnt++;
      end
    end
    foreach (code_sym[i]) code_sym[i] = SYM_W'($urandom_range(0, 255));
  endtask

  task automatic send_code(input int c, input op_t op, input int noise_pct);
    for (int j = 0; j < code_len[c]; j++) begin
      if (op == OP_BUILD)
        queue_bit(op, code_bits[c][j], j == code_len[c] - 1, code_sym[c]);
      else
        queue_bit(op, code_bits[c][j], 1'($urandom_range(0, 1)),
                  SYM_W'($urandom_range(0, 255)));
      maybe_noise(noise_pct);
    end
  endtask

  task automatic wait_idle();
    while (bit_reqs_pending.size() != 0 || in_valid || answers_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input int m);
    case (m)
      1: begin send_idle_pct = 63; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 63; end
      3: begin send_idle_pct = 16; recv_stall_pct = 16; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic run_round(input int mode, input logic [CNT_W-1:0] lim, input bit do_clear,
                           input int noise_pct, input bit pressure);
    int n_words;
    wait_idle();
    write_limit(lim);
    set_mode(mode);
    if (pressure) hold_left = HOLD_CYCLES;
    if (do_clear) begin
      queue_bit(OP_CLEAR, 1'b0, 1'b0, '0);
      grow_code_set();
      for (int c = 0; c < code_cnt; c++)
        // skip a code now and then so decoding can run into a missing child
        if (noise_pct == 0 || $urandom_range(0, 99) >= 10) send_code(c, OP_BUILD, noise_pct);
    end
    n_words = $urandom_range(8, 25);
    repeat (n_words) send_code($urandom_range(0, code_cnt - 1), OP_DECODE, noise_pct);
  endtask

  // Grow one mostly fresh path after another until the node store runs out
  task automatic fill_store(input int mode);
    wait_idle();
    write_limit('0);
    set_mode(mode);
    queue_bit(OP_CLEAR, 1'b0, 1'b0, '0);
    full_predicted = 0;
    while (full_predicted < 3)
      queue_bit(OP_BUILD, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 5,
                SYM_W'($urandom_range(0, 255)));
    repeat (40) queue_bit(OP_DECODE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          SYM_W'($urandom_range(0, 255)));
  endtask

  // Sender: advance to the next request once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (bit_reqs_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= bit_reqs_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_rsp_t want;
    cycle_cnt++;
    in_fire = in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected answer: kind %0d, out_symbol %0h", out_data.kind,
               out_data.out_symbol);
        err_cnt++;
      end else begin
        want = answers_due.pop_front();
        answers_checked++;
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_data.kind);
          err_cnt++;
        end
        if (out_data.out_symbol !== want.out_symbol) begin
          $error("out_symbol: expected %0h, actual %0h", want.out_symbol,
                 out_data.out_symbol);
          err_cnt++;
        end
        if (out_data.final_symbol !== want.final_symbol) begin
          $error("final_symbol: expected %0b, actual %0b", want.final_symbol,
                 out_data.final_symbol);
          err_cnt++;
        end
        case (out_data.kind)
          KIND_SYMBOL:  symbols_seen++;
          KIND_INVALID: invalid_seen++;
          KIND_FULL:    full_seen++;
          default: ;
        endcase
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("huffman_tree_build_and_decode_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] lim;
    int               r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    foreach (node_left[i]) begin
      node_left[i] = '0;
      node_right[i] = '0;
      node_sym[i] = '0;
      node_leaf[i] = 1'b0;
    end
    reset_tree();
    limit_shadow = '0;
    code_cnt = 0;

    // Small tree: 0 -> 00h, 10 -> FFh, 11 -> A5h; then rebuild, grow under a leaf, halt
    dir_tab[0]  = row_exp(op_t'(OP_UNUSED), 1'b0, 1'b0, 8'h00, KIND_NONE, 8'h00, 1'b0);
    dir_tab[1]  = row_exp(OP_BUILD,  1'b0, 1'b1, 8'h00, KIND_NONE, 8'h00, 1'b0);
    dir_tab[2]  = row    (OP_BUILD,  1'b1, 1'b0, 8'hFF);
    dir_tab[3]  = row    (OP_BUILD,  1'b0, 1'b1, 8'hFF);
    dir_tab[4]  = row    (OP_BUILD,  1'b1, 1'b0, 8'h00);
    dir_tab[5]  = row    (OP_BUILD,  1'b1, 1'b1, 8'hA5);
    dir_tab[6]  = row_exp(OP_DECODE, 1'b0, 1'b0, 8'h00, KIND_SYMBOL, 8'h00, 1'b0);
    dir_tab[7]  = row    (OP_DECODE, 1'b1, 1'b1, 8'hFF);
    dir_tab[8]  = row_exp(OP_DECODE, 1'b0, 1'b0, 8'h00, KIND_SYMBOL, 8'hFF, 1'b0);
    dir_tab[9]  = row    (OP_DECODE, 1'b1, 1'b0, 8'h00);
    dir_tab[10] = row_exp(OP_DECODE, 1'b1, 1'b0, 8'h00, KIND_SYMBOL, 8'hA5, 1'b0);
    dir_tab[11] = row    (OP_BUILD,  1'b0, 1'b1, 8'h3C);
    dir_tab[12] = row    (OP_BUILD,  1'b0, 1'b0, 8'h00);
    dir_tab[13] = row    (OP_BUILD,  1'b1, 1'b1, 8'h5A);
    dir_tab[14] = row    (OP_DECODE, 1'b0, 1'b0, 8'h00);
    dir_tab[15] = row_exp(OP_CLEAR,  1'b1, 1'b1, 8'hFF, KIND_NONE, 8'h00, 1'b0);
    dir_tab[16] = row_exp(OP_DECODE, 1'b1, 1'b0, 8'h00, KIND_INVALID, 8'h00, 1'b0);
    dir_tab[17] = row_exp(OP_DECODE, 1'b0, 1'b0, 8'h00, KIND_IGNORED, 8'h00, 1'b0);
    dir_tab[18] = row    (OP_BUILD,  1'b1, 1'b1, 8'h80);
    dir_tab[19] = row_exp(OP_DECODE, 1'b1, 1'b0, 8'h00, KIND_IGNORED, 8'h00, 1'b0);
    dir_tab[20] = row_exp(OP_CLEAR,  1'b0, 1'b0, 8'h00, KIND_NONE, 8'h00, 1'b0);
    dir_tab[21] = row    (OP_BUILD,  1'b1, 1'b1, 8'h80);
    dir_tab[22] = row    (OP_DECODE, 1'b1, 1'b0, 8'h00);
    dir_tab[23] = row_exp(OP_DECODE, 1'b0, 1'b0, 8'h00, KIND_INVALID, 8'h00, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      queue_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

    run_round(0, LIMIT_MAX, 1'b1, 0, 1'b0);
    run_round(1, 24'd1, 1'b1, 0, 1'b0);
    run_round(2, CNT_W'($urandom_range(5, 40)), 1'b1, 8, 1'b1);
    run_round(3, '0, 1'b1, 0, 1'b0);
    // count is already past this limit: halt at the next symbol
    run_round(0, 24'd2, 1'b0, 0, 1'b0);
    fill_store(1);
    r = 2;
    while (reqs_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: lim = '0;
        1: lim = LIMIT_MAX;
        2: lim = CNT_W'($urandom_range(1, 40));
        default: lim = CNT_W'($urandom_range(1, LIMIT_MAX));
      endcase
      run_round(r % 4, lim, $urandom_range(0, 3) != 0, 8, 1'b0);
      r++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run: %0d requests, %0d answers checked across several limits and stall mixes.",
             reqs_queued, answers_checked);
    $display("Seen: %0d symbols, %0d invalid-path halts, %0d store-full answers.",
             symbols_seen, invalid_seen, full_seen);
    if (err_cnt == 0)
      $display("huffman_tree_build_and_decode_unit verification clean");
    else
      $display("huffman_tree_build_and_decode_unit verification failed");
    $finish;
  end

endmodule
